// ----- rtl/scbbe_pkg.sv -----
package scbbe_pkg;

  localparam int SLOTS = 128;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;

  localparam logic [7:0] DEFAULT_COUNT = 8'd100;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

  localparam logic [2:0] K_OPEN    = 3'd0;
  localparam logic [2:0] K_CLOSE   = 3'd1;
  localparam logic [2:0] K_RELEASE = 3'd2;
  localparam logic [2:0] K_LOCK    = 3'd3;
  localparam logic [2:0] K_UNLOCK  = 3'd4;
  localparam logic [2:0] K_DESTROY = 3'd5;
  localparam logic [2:0] K_FREE    = 3'd6;
  localparam logic [2:0] K_FLUSH   = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSLOT  = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_INUSE   = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  localparam logic [0:0] REG_LIMIT = 1'd0;
  localparam logic [0:0] REG_COUNT = 1'd1;

  // marks: [0] locked, [1] open, [2] valid
  localparam int MK_LOCKED = 0;
  localparam int MK_OPEN   = 1;
  localparam int MK_VALID  = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  slot;
    logic [31:0] file_bytes;
    logic [39:0] requested_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  granted_slot;
    logic [39:0] bytes_freed;
    logic [7:0]  slots_evicted;
    logic [7:0]  busy_count;
    logic [39:0] bytes_held;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic        load;     // latch request, clear step counters
    logic        mod_step; // one step of pointer modulo slot count
    logic        rd;       // read slot at idx
    logic [1:0]  idx_sel;  // 0 walk pointer, 1 addressed slot
    logic        scan_init_fwd;
    logic        scan_init_back;
    logic        scan_init_zero;
    logic        scan_step_fwd;
    logic        scan_step_back;
    logic        act_claim;   // open claim on read slot
    logic        act_evict;   // evict read slot if valid idle
    logic        act_flush;   // flush visit
    logic        act_addr;    // addressed-slot operation
    logic        add_close;   // add size to total
    logic        finish;      // form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       addr_ok;    // addressed slot in range and valid, after its read
    logic       rd_busy;    // valid and busy
    logic       walk_done;  // budget satisfied
    logic       scan_last;  // scan at its end
    logic       mod_last;   // pointer modulo on its last step
    logic       one_slot;   // single live slot, walk visits nothing
    logic       clearing;   // slot table clear after reset
  } sts_t;

endpackage

// ----- rtl/scbbe_if.sv -----
interface scbbe_req_if;
  import scbbe_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scbbe_rsp_if;
  import scbbe_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/slot_cache_with_byte_budget_eviction.sv -----
// Slot cache with byte-budget eviction.
// Requests come in on req (valid/ready); each request gives exactly one
// response word on rsp (valid/ready). Configuration is a write port:
// cfg_we, cfg_idx (0 byte limit, 1 slot count), cfg_data.
// One request at a time: req_ready is high only while the block is idle.
// Every request first reduces the pointer modulo the slot count N. Open
// visits up to N slots and flush visits all N; the eviction walk of a
// free-space request or a close visits at most N-1 slots. A new request
// can be taken in the cycle after the response is delivered; the slot
// table is read once per visit.
// The response waits in place while rsp_ready is low; no new request is
// taken until it is delivered.
// Reset clears the pointer and byte total, sets the byte limit to 0 (no
// limit) and the slot count to 100, then empties the slot table one entry
// per cycle; requests are held off until the table is empty.
module slot_cache_with_byte_budget_eviction
  import scbbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  scbbe_req_if.sink   req,
  scbbe_rsp_if.source rsp,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [39:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  scbbe_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  scbbe_datapath u_dp (
    .clk(clk), .rst(rst), .req(req.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .rsp(rsp.data)
  );

endmodule

// ----- rtl/scbbe_datapath.sv -----
module scbbe_datapath
  import scbbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [39:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output rsp_t        rsp
);

  logic [2:0]  marks [SLOTS];
  logic [31:0] sizes [SLOTS];
  logic [SW-1:0] next_slot;
  logic [39:0] total;
  logic [39:0] byte_limit;
  logic [7:0]  slot_count;
  req_t        r;
  logic [SW-1:0] idx;
  logic [CW-1:0] visits;
  logic [2:0]  rd_mk;
  logic [31:0] rd_sz;
  logic [SW-1:0] rd_idx;
  logic [39:0] freed;      // walk sum, saturated, compared against the request
  logic [39:0] step_freed;
  logic [7:0]  evicted;
  logic [7:0]  busy;
  logic [2:0]  status;
  logic [6:0]  granted;
  logic        found;
  logic        addr_hit;
  logic        clearing;
  logic [SW-1:0] clr_idx;
  logic [SW-1:0] pm_rem;
  logic [2:0]  pm_bit;

  // effective slot count
  logic [7:0] n_raw;
  logic [CW-1:0] n;
  always_comb begin
    n_raw = (slot_count == 8'd0) ? DEFAULT_COUNT : slot_count;
    n = (CW'(n_raw) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(n_raw);
  end

  // shifted slot count for the pointer modulo
  logic [SW+CW-1:0] pm_sub;
  assign pm_sub = (SW+CW)'(n) << pm_bit;

  logic [SW-1:0] idx_inc, last;
  assign last    = SW'(n - CW'(1));
  logic [SW-1:0] idx_dec;
  assign idx_dec = (idx == '0) ? last : idx - SW'(1);
  assign idx_inc = (CW'(idx) + CW'(1) >= n) ? '0 : idx + SW'(1);

  logic rd_valid, rd_busy;
  assign rd_valid = rd_mk[MK_VALID];
  assign rd_busy  = rd_valid && (rd_mk[MK_OPEN] || rd_mk[MK_LOCKED]);

  logic addr_ok;
  assign addr_ok = (CW'(r.slot) < n) && rd_mk[MK_VALID];

  logic [39:0] need;
  assign need = (r.kind == K_CLOSE) ? '0 : r.requested_bytes;

  logic [39:0] tot_sub, fr_add, sf_add, tot_add;
  logic [40:0] sf_sum, ta_sum, fr_sum;
  always_comb begin
    tot_sub = (total >= 40'(rd_sz)) ? total - 40'(rd_sz) : '0;
    sf_sum  = {1'b0, step_freed} + 41'(rd_sz);
    sf_add  = sf_sum[40] ? MAX40 : sf_sum[39:0];
    fr_sum  = {1'b0, freed} + 41'(rd_sz);
    fr_add  = fr_sum[40] ? MAX40 : fr_sum[39:0];
    ta_sum  = {1'b0, total} + 41'(r.file_bytes);
    tot_add = ta_sum[40] ? MAX40 : ta_sum[39:0];
  end

  assign sts.kind      = r.kind;
  assign sts.addr_ok   = addr_ok;
  assign sts.rd_busy   = rd_busy;
  assign sts.walk_done = ((byte_limit == '0) || (total <= byte_limit)) &&
                         (freed >= need);
  assign sts.scan_last = (visits == '0);
  assign sts.mod_last  = (pm_bit == 3'd0);
  assign sts.one_slot  = (n == CW'(1));
  assign sts.clearing  = clearing;

  always_comb begin
    case (cmd.idx_sel)
      2'd1:    rd_idx = SW'(r.slot);
      default: rd_idx = idx;
    endcase
  end

  // slot memory; one entry cleared per cycle after reset
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_mk <= marks[rd_idx];
      rd_sz <= sizes[rd_idx];
    end
    if (clearing) begin
      marks[clr_idx] <= 3'b000;
    end else if (cmd.act_claim && !rd_busy) begin
      marks[idx] <= 3'b110;
      sizes[idx] <= '0;
    end else if ((cmd.act_evict || cmd.act_flush) && rd_valid && !rd_busy) begin
      marks[idx] <= 3'b000;
    end else if (cmd.act_addr) begin
      case (r.kind)
        K_CLOSE: begin
          marks[SW'(r.slot)] <= 3'b101;
          sizes[SW'(r.slot)] <= r.file_bytes;
        end
        K_RELEASE: marks[SW'(r.slot)] <= 3'b100;
        K_LOCK:    marks[SW'(r.slot)] <= rd_mk | 3'b001;
        K_UNLOCK:  marks[SW'(r.slot)] <= rd_mk & 3'b110;
        K_DESTROY: marks[SW'(r.slot)] <= 3'b000;
        default:   marks[SW'(r.slot)] <= rd_mk;
      endcase
    end
  end

  // registers, step counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot  <= '0;
      total      <= '0;
      byte_limit <= '0;
      slot_count <= DEFAULT_COUNT;
      clearing   <= 1'b1;
      clr_idx    <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + SW'(1);
        if (clr_idx == SW'(SLOTS - 1)) clearing <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_idx == REG_LIMIT) byte_limit <= cfg_data;
        else slot_count <= cfg_data[7:0];
      end
      if (cmd.load) begin
        r <= req;
        step_freed <= '0;
        freed <= '0;
        evicted <= '0;
        busy <= '0;
        found <= 1'b0;
        addr_hit <= 1'b0;
        status <= ST_OK;
        granted <= req.slot;
        pm_rem <= next_slot;
        pm_bit <= 3'(SW - 1);
      end
      // restoring remainder of the pointer by the slot count
      if (cmd.mod_step) begin
        if ((SW+CW)'(pm_rem) >= pm_sub) pm_rem <= pm_rem - SW'(pm_sub);
        pm_bit <= pm_bit - 3'd1;
      end
      if (cmd.scan_init_fwd) begin
        idx <= pm_rem; visits <= n - CW'(1);
      end
      if (cmd.scan_init_back) begin
        idx <= (pm_rem == '0) ? last : pm_rem - SW'(1);
        visits <= n - CW'(2);
      end
      if (cmd.scan_init_zero) begin
        idx <= '0; visits <= n - CW'(1);
      end
      if (cmd.scan_step_fwd) begin
        idx <= idx_inc; visits <= visits - CW'(1);
      end
      if (cmd.scan_step_back) begin
        idx <= idx_dec; visits <= visits - CW'(1);
      end
      if (cmd.act_claim && !rd_busy) begin
        found <= 1'b1;
        granted <= 7'(idx);
        next_slot <= idx_inc;
        if (rd_valid) begin
          total <= tot_sub; step_freed <= sf_add; evicted <= evicted + 8'd1;
        end
      end
      if ((cmd.act_evict || cmd.act_flush) && rd_valid && !rd_busy) begin
        total <= tot_sub; step_freed <= sf_add; freed <= fr_add;
        evicted <= evicted + 8'd1;
      end
      if (cmd.act_flush && rd_busy) busy <= busy + 8'd1;
      if (cmd.act_addr) addr_hit <= 1'b1;
      if (cmd.add_close) total <= tot_add;
      if (cmd.act_addr && r.kind == K_DESTROY) begin
        total <= tot_sub; step_freed <= sf_add; evicted <= evicted + 8'd1;
      end
      if (cmd.finish) begin
        case (r.kind)
          K_OPEN: if (!found) begin status <= ST_NOSLOT; granted <= '0; end
          K_FREE: status <= (step_freed != '0) ? ST_OK : ST_NOFREE;
          K_FLUSH: status <= (busy != '0) ? ST_INUSE : ST_OK;
          default: status <= addr_hit ? ST_OK : ST_INVALID;
        endcase
      end
    end
  end

  assign rsp.status        = status;
  assign rsp.granted_slot  = granted;
  assign rsp.bytes_freed   = step_freed;
  assign rsp.slots_evicted = evicted;
  assign rsp.busy_count    = busy;
  assign rsp.bytes_held    = total;

endmodule

// ----- rtl/scbbe_ctrl.sv -----
module scbbe_ctrl
  import scbbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ORD   = 4'd2;
  localparam logic [3:0] S_OCHK  = 4'd3;
  localparam logic [3:0] S_ARD   = 4'd4;
  localparam logic [3:0] S_AACT  = 4'd5;
  localparam logic [3:0] S_WCHK  = 4'd6;
  localparam logic [3:0] S_WACT  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FACT  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_WINIT = 4'd12;
  localparam logic [3:0] S_MOD   = 4'd13;

  logic [3:0] state, state_next;
  logic       wscan_empty, wscan_empty_next;

  assign in_ready  = (state == S_IDLE) && !sts.clearing;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    wscan_empty_next = wscan_empty;
    case (state)
      S_IDLE: if (in_valid && !sts.clearing) begin
        cmd.load = 1'b1; state_next = S_MOD;
      end
      // reduce the pointer modulo the slot count, one bit per cycle
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_DISP;
      end
      S_DISP: begin
        case (sts.kind)
          K_OPEN:  begin cmd.scan_init_fwd = 1'b1; state_next = S_ORD; end
          K_FREE:  begin cmd.scan_init_back = 1'b1; state_next = S_WINIT; end
          K_FLUSH: begin cmd.scan_init_zero = 1'b1; state_next = S_FRD; end
          default: state_next = S_ARD;
        endcase
      end
      // open: read then test one slot per visit
      S_ORD: begin cmd.rd = 1'b1; state_next = S_OCHK; end
      S_OCHK: begin
        cmd.act_claim = 1'b1;
        if (!sts.rd_busy) state_next = S_FIN;
        else if (sts.scan_last) state_next = S_FIN;
        else begin cmd.scan_step_fwd = 1'b1; state_next = S_ORD; end
      end
      // addressed operations
      S_ARD: begin
        cmd.rd = 1'b1; cmd.idx_sel = 2'd1;
        state_next = S_AACT;
      end
      S_AACT: begin
        if (!sts.addr_ok) state_next = S_FIN;
        else begin
          cmd.act_addr = 1'b1;
          if (sts.kind == K_CLOSE) begin
            cmd.add_close = 1'b1; cmd.scan_init_back = 1'b1; state_next = S_WINIT;
          end else state_next = S_FIN;
        end
      end
      // eviction walk, n-1 slots at most
      S_WINIT: begin
        wscan_empty_next = sts.one_slot;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (sts.walk_done || wscan_empty) state_next = S_FIN;
        else begin cmd.rd = 1'b1; state_next = S_WACT; end
      end
      S_WACT: begin
        cmd.act_evict = 1'b1;
        if (sts.scan_last) wscan_empty_next = 1'b1;
        else cmd.scan_step_back = 1'b1;
        state_next = S_WCHK;
      end
      // flush every slot
      S_FRD: begin cmd.rd = 1'b1; state_next = S_FACT; end
      S_FACT: begin
        cmd.act_flush = 1'b1;
        if (sts.scan_last) state_next = S_FIN;
        else begin cmd.scan_step_fwd = 1'b1; state_next = S_FRD; end
      end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_OUT; end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state register; the empty-walk flag is loaded in S_WINIT, set when n is 1
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wscan_empty <= 1'b0;
    end else begin
      state <= state_next;
      wscan_empty <= wscan_empty_next;
    end
  end

endmodule
